### hdl/fpl_pkg.sv
// ----------------------------------------------------------------------------
// fpl_pkg: shared types, constants and microcode for the ladder lowpass
// Fixed-point widths, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package fpl_pkg;

  // Structure and formats
  localparam int unsigned STAGES          = 4;
  localparam int unsigned IDX_W           = $clog2(STAGES);
  localparam int unsigned DEF_SAMPLE_BITS = 24;
  localparam int unsigned QF              = 20;
  localparam int unsigned ONE_Q           = 1 << QF;

  // Register widths
  localparam int unsigned COEF_W     = 21;
  localparam int unsigned RES_W      = 23;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  // Datapath widths, sized for the widest sample format (32 bits)
  localparam int unsigned ST_W   = 32;               // integrators, sigma, u, lp
  localparam int unsigned GAIN_W = 25;               // 1.0 + bc*k, Q.20
  localparam int unsigned MC_W   = 25;               // coefficient operand
  localparam int unsigned MD_W   = 33;               // data operand
  localparam int unsigned PROD_W = MC_W + 1 + MD_W;  // product register
  localparam int unsigned ACC_W  = 60;               // accumulator
  localparam int unsigned T_W    = 38;               // xs / diff / v scratch
  localparam int unsigned SAT_W  = ACC_W - QF;       // saturator input
  localparam int unsigned DLO_W  = 16;               // low slice of diff

  localparam int unsigned PC_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STAGE_GAIN = 3'd0,
    REG_LOOP_NORM  = 3'd1,
    REG_RESONANCE  = 3'd2,
    REG_BASS_COMP  = 3'd3,
    REG_BETA_ONE   = 3'd4,
    REG_BETA_TWO   = 3'd5,
    REG_BETA_THREE = 3'd6,
    REG_BETA_FOUR  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,      // acc <= 0
    OP_MUL,      // prod <= coef * data
    OP_ACC_ADD,  // acc <= acc + prod
    OP_ACC_HI,   // acc <= prod << DLO_W
    OP_SIGMA,    // sigma <= sat(acc >>> QF)
    OP_GAIN,     // gain <= 1.0 + prod >> QF
    OP_XS,       // t <= prod >>> QF
    OP_DIFF,     // t <= t - prod >>> QF
    OP_U,        // sig <= sat(acc >>> QF)
    OP_SUB,      // t <= sig - s[idx]
    OP_V,        // t <= prod >>> QF
    OP_LP,       // sig <= sat(t + s[idx])
    OP_ST        // s[idx] <= sat(t + sig)
  } op_e;

  typedef enum logic [2:0] {
    C_NONE, C_BETA, C_BC, C_GAIN, C_K, C_NORM, C_ALPHA
  } csel_e;

  typedef enum logic [2:0] {
    D_NONE, D_STATE, D_K, D_X, D_SIGMA, D_DHI, D_DLO, D_T
  } dsel_e;

  typedef enum logic [2:0] {
    J_NEXT,   // fall through
    J_WAIT,   // hold until an item is accepted
    J_LOOP,   // back to tgt until the last stage, then fall through
    J_DONE,   // hand the result over, then back to the start
    J_HOME    // back to the start
  } jmp_e;

  typedef struct packed {
    logic [COEF_W-1:0]              stage_gain;
    logic [COEF_W-1:0]              loop_norm;
    logic [RES_W-1:0]               resonance;
    logic [COEF_W-1:0]              bass_comp;
    logic [STAGES-1:0][COEF_W-1:0]  beta;
  } coef_t;

  typedef struct packed {
    op_e             op;
    csel_e           csel;
    dsel_e           dsel;
    jmp_e            jmp;
    logic [PC_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    op_e              op;
    csel_e            csel;
    dsel_e            dsel;
    logic [IDX_W-1:0] idx;
    logic             ld_x;
  } uop_t;

  localparam logic [PC_W-1:0] UC_SIGMA_LOOP = PC_W'(1);
  localparam logic [PC_W-1:0] UC_STAGE_LOOP = PC_W'(15);

  // Clamp to the signed ST_W range
  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SAT_W-1:0] a);
    logic [SAT_W-ST_W:0] top;
    top = a[SAT_W-1:ST_W-1];
    if ((&top) || !(|top)) begin
      return a[ST_W-1:0];
    end else if (a[SAT_W-1]) begin
      return {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ST_W-1){1'b1}}};
    end
  endfunction

  // Sequencer program
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{op: OP_NOP, csel: C_NONE, dsel: D_NONE, jmp: J_NEXT, tgt: '0};
    case (pc)
      PC_W'(0):  begin w.op = OP_CLR; w.jmp = J_WAIT; end
      // sigma = sum beta_i * s_i
      PC_W'(1):  begin w.op = OP_MUL; w.csel = C_BETA; w.dsel = D_STATE; end
      PC_W'(2):  begin w.op = OP_ACC_ADD; w.jmp = J_LOOP; w.tgt = UC_SIGMA_LOOP; end
      PC_W'(3):  w.op = OP_SIGMA;
      // input gain
      PC_W'(4):  begin w.op = OP_MUL; w.csel = C_BC; w.dsel = D_K; end
      PC_W'(5):  w.op = OP_GAIN;
      PC_W'(6):  begin w.op = OP_MUL; w.csel = C_GAIN; w.dsel = D_X; end
      PC_W'(7):  w.op = OP_XS;
      PC_W'(8):  begin w.op = OP_MUL; w.csel = C_K; w.dsel = D_SIGMA; end
      PC_W'(9):  w.op = OP_DIFF;
      // u = norm * diff, diff split in two slices
      PC_W'(10): begin w.op = OP_MUL; w.csel = C_NORM; w.dsel = D_DHI; end
      PC_W'(11): w.op = OP_ACC_HI;
      PC_W'(12): begin w.op = OP_MUL; w.csel = C_NORM; w.dsel = D_DLO; end
      PC_W'(13): w.op = OP_ACC_ADD;
      PC_W'(14): w.op = OP_U;
      // one-pole stages
      PC_W'(15): w.op = OP_SUB;
      PC_W'(16): begin w.op = OP_MUL; w.csel = C_ALPHA; w.dsel = D_T; end
      PC_W'(17): w.op = OP_V;
      PC_W'(18): w.op = OP_LP;
      PC_W'(19): begin w.op = OP_ST; w.jmp = J_LOOP; w.tgt = UC_STAGE_LOOP; end
      PC_W'(20): w.jmp = J_DONE;
      default:   w.jmp = J_HOME;
    endcase
    return w;
  endfunction

endpackage

### hdl/fpl_if.sv
// ----------------------------------------------------------------------------
// fpl_if: channel interfaces of the ladder lowpass
// Sample input, sample output and register write channels.
// ----------------------------------------------------------------------------
interface fpl_in_if #(
  parameter int unsigned SAMPLE_BITS = fpl_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fpl_out_if #(
  parameter int unsigned SAMPLE_BITS = fpl_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface fpl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpl_pkg::CFG_IDX_W-1:0]   index;
  logic [fpl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/fpl_sequencer.sv
// ----------------------------------------------------------------------------
// fpl_sequencer: microcode sequencer
// Step counter, stage counter and program ROM; issues one micro-op a cycle.
// ----------------------------------------------------------------------------
module fpl_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_busy_i,
  output logic          in_ready_o,
  output logic          out_load_o,
  output fpl_pkg::uop_t uop_o
);
  import fpl_pkg::*;

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  ctl_t             ctl;

  assign ctl = ucode(pc_q);

  always_comb begin
    pc_d       = pc_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (ctl.jmp)
      J_NEXT: pc_d = pc_q + 1'b1;
      J_WAIT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pc_d = pc_q + 1'b1;
        end
      end
      J_LOOP: begin
        if (idx_q == IDX_W'(STAGES - 1)) begin
          idx_d = '0;
          pc_d  = pc_q + 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
          pc_d  = ctl.tgt;
        end
      end
      J_DONE: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          pc_d       = '0;
        end
      end
      J_HOME:  pc_d = '0;
      default: pc_d = '0;
    endcase
  end

  assign uop_o = '{op:   ctl.op,
                   csel: ctl.csel,
                   dsel: ctl.dsel,
                   idx:  idx_q,
                   ld_x: in_ready_o && in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      idx_q <= '0;
    end else begin
      pc_q  <= pc_d;
      idx_q <= idx_d;
    end
  end

endmodule

### hdl/fpl_datapath.sv
// ----------------------------------------------------------------------------
// fpl_datapath: shared multiply-accumulate datapath
// One registered multiplier, accumulator, scratch registers, four integrators.
// ----------------------------------------------------------------------------
module fpl_datapath #(
  parameter int unsigned SAMPLE_BITS = fpl_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpl_pkg::uop_t                 uop_i,
  input  fpl_pkg::coef_t                coef_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);
  import fpl_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [T_W-1:0]         t_q;
  logic signed [ST_W-1:0]        sgm_q;
  logic signed [ST_W-1:0]        sig_q;
  logic [GAIN_W-1:0]             gain_q;
  logic signed [ST_W-1:0]        st_q [STAGES];

  logic [MC_W-1:0]               mc;
  logic signed [MD_W-1:0]        md;
  logic signed [ST_W-1:0]        st_rd;
  logic signed [PROD_W-QF-1:0]   prod_sh;
  logic [ST_W-SAMPLE_BITS:0]     y_top;

  assign st_rd   = st_q[uop_i.idx];
  assign prod_sh = prod_q[PROD_W-1:QF];

  // Coefficient operand (unsigned)
  always_comb begin
    case (uop_i.csel)
      C_BETA:  mc = MC_W'(coef_i.beta[uop_i.idx]);
      C_BC:    mc = MC_W'(coef_i.bass_comp);
      C_GAIN:  mc = MC_W'(gain_q);
      C_K:     mc = MC_W'(coef_i.resonance);
      C_NORM:  mc = MC_W'(coef_i.loop_norm);
      C_ALPHA: mc = MC_W'(coef_i.stage_gain);
      default: mc = '0;
    endcase
  end

  // Data operand (signed)
  always_comb begin
    case (uop_i.dsel)
      D_STATE: md = MD_W'(st_rd);
      D_K:     md = $signed(MD_W'(coef_i.resonance));
      D_X:     md = MD_W'(x_q);
      D_SIGMA: md = MD_W'(sgm_q);
      D_DHI:   md = MD_W'(t_q >>> DLO_W);
      D_DLO:   md = $signed(MD_W'(t_q[DLO_W-1:0]));
      D_T:     md = MD_W'(t_q);
      default: md = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (uop_i.ld_x) begin
      x_q <= x_i;
    end
    case (uop_i.op)
      OP_CLR:     acc_q  <= '0;
      OP_MUL:     prod_q <= PROD_W'($signed({1'b0, mc})) * PROD_W'(md);
      OP_ACC_ADD: acc_q  <= acc_q + ACC_W'(prod_q);
      OP_ACC_HI:  acc_q  <= ACC_W'(prod_q) <<< DLO_W;
      OP_SIGMA:   sgm_q  <= sat_st(SAT_W'(acc_q >>> QF));
      OP_GAIN:    gain_q <= GAIN_W'(prod_sh) + GAIN_W'(ONE_Q);
      OP_XS:      t_q    <= T_W'(prod_sh);
      OP_DIFF:    t_q    <= t_q - T_W'(prod_sh);
      OP_U:       sig_q  <= sat_st(SAT_W'(acc_q >>> QF));
      OP_SUB:     t_q    <= T_W'(sig_q) - T_W'(st_rd);
      OP_V:       t_q    <= T_W'(prod_sh);
      OP_LP:      sig_q  <= sat_st(SAT_W'(t_q) + SAT_W'(st_rd));
      default:    ;
    endcase
  end

  // Integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) begin
        st_q[i] <= '0;
      end
    end else if (uop_i.op == OP_ST) begin
      st_q[uop_i.idx] <= sat_st(SAT_W'(t_q) + SAT_W'(sig_q));
    end
  end

  // Output clamp to the sample range
  assign y_top = sig_q[ST_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_o = sig_q[SAMPLE_BITS-1:0];
    end else if (sig_q[ST_W-1]) begin
      y_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

### hdl/four_pole_ladder_lowpass.sv
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass: four-pole ladder lowpass with resonance feedback
// Microcoded sequencer over one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// A new item is accepted only after the previous result has been loaded into
//   the output register, which waits while a result is still unread; each
//   item costs the 21-step program, with the sigma and stage sections run
//   four times each through the single registered multiplier.
// Reset: integrators cleared, registers to their reset values, sequencer at
//   its wait step, output empty. No clearing pass.
module four_pole_ladder_lowpass #(
  parameter int unsigned SAMPLE_BITS = fpl_pkg::DEF_SAMPLE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpl_cfg_if.sink    cfg_ch,
  fpl_in_if.sink     in_ch,
  fpl_out_if.source  out_ch
);
  import fpl_pkg::*;

  // Register file
  logic [COEF_W-1:0]             stage_gain_q;
  logic [COEF_W-1:0]             loop_norm_q;
  logic [RES_W-1:0]              resonance_q;
  logic [COEF_W-1:0]             bass_comp_q;
  logic [STAGES-1:0][COEF_W-1:0] beta_q;
  coef_t                         coef;

  // Sequencer / datapath hookup
  uop_t                          uop;
  logic                          in_ready;
  logic                          out_load;
  logic                          out_busy;
  logic signed [SAMPLE_BITS-1:0] y;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_data_q;

  // Writes are always taken; only legal while idle, so no hazard with the
  // datapath reading the coefficients.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_gain_q <= COEF_W'(ONE_Q >> 1);
      loop_norm_q  <= COEF_W'(ONE_Q);
      resonance_q  <= '0;
      bass_comp_q  <= '0;
      beta_q       <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_e'(cfg_ch.index))
        REG_STAGE_GAIN: stage_gain_q <= cfg_ch.data[COEF_W-1:0];
        REG_LOOP_NORM:  loop_norm_q  <= cfg_ch.data[COEF_W-1:0];
        REG_RESONANCE:  resonance_q  <= cfg_ch.data[RES_W-1:0];
        REG_BASS_COMP:  bass_comp_q  <= cfg_ch.data[COEF_W-1:0];
        REG_BETA_ONE:   beta_q[0]    <= cfg_ch.data[COEF_W-1:0];
        REG_BETA_TWO:   beta_q[1]    <= cfg_ch.data[COEF_W-1:0];
        REG_BETA_THREE: beta_q[2]    <= cfg_ch.data[COEF_W-1:0];
        REG_BETA_FOUR:  beta_q[3]    <= cfg_ch.data[COEF_W-1:0];
        default:        ;
      endcase
    end
  end

  assign coef = '{stage_gain: stage_gain_q,
                  loop_norm:  loop_norm_q,
                  resonance:  resonance_q,
                  bass_comp:  bass_comp_q,
                  beta:       beta_q};

  // Output stage stalls the final step only while a result is still unread
  assign out_busy = out_valid_q && !out_ch.ready;

  fpl_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .out_busy_i (out_busy),
    .in_ready_o (in_ready),
    .out_load_o (out_load),
    .uop_o      (uop)
  );

  fpl_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .uop_i  (uop),
    .coef_i (coef),
    .x_i    (in_ch.sample_in),
    .y_o    (y)
  );

  assign in_ch.ready = in_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= y;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.sample_out = out_data_q;

endmodule

### verif/ladder_response_checker.sv
// ----------------------------------------------------------------------------
// ladder_response_checker: output predictor and comparator for the ladder
// Tracks register writes and accepted samples, predicts each filtered sample
// in fixed point and checks every result item against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module ladder_response_checker #(
  parameter int unsigned SAMPLE_BITS = fpl_pkg::DEF_SAMPLE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  fpl_cfg_if   cfg_ch,
  fpl_in_if    in_ch,
  fpl_out_if   out_ch,
  output int   failures_o,
  output int   pending_o,
  output int   checked_o
);
  import fpl_pkg::*;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;
  localparam longint OUT_MAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN   = -OUT_MAX - 1;
  localparam int     REPORT_MAX = 10;

  logic [COEF_W-1:0] stage_gain_q;
  logic [COEF_W-1:0] loop_norm_q;
  logic [RES_W-1:0]  resonance_q;
  logic [COEF_W-1:0] bass_comp_q;
  logic [COEF_W-1:0] beta_q [STAGES];
  longint            integ_state [STAGES];

  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  int mismatch_count  = 0;
  int pending_count   = 0;
  int results_checked = 0;

  assign failures_o = mismatch_count;
  assign pending_o  = pending_count;
  assign checked_o  = results_checked;

  function automatic longint clamp_range(input longint a, input longint lo, input longint hi);
    if (a < lo) begin
      return lo;
    end else if (a > hi) begin
      return hi;
    end
    return a;
  endfunction

  // One sample through the loop; products with Q.20 coefficients floor-shifted
  function automatic logic signed [SAMPLE_BITS-1:0] ladder_filter_step(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    longint sigma;
    longint in_gain;
    longint x_scaled;
    longint diff;
    longint sig;
    longint s;
    longint v;
    longint lp;
    int     i;
    sigma = 0;
    for (i = 0; i < STAGES; i++) begin
      sigma += longint'(beta_q[i]) * integ_state[i];
    end
    sigma    = clamp_range(sigma >>> QF, INTEG_MIN, INTEG_MAX);
    in_gain  = longint'(ONE_Q) + ((longint'(bass_comp_q) * longint'(resonance_q)) >>> QF);
    x_scaled = (longint'(x) * in_gain) >>> QF;
    diff     = x_scaled - ((longint'(resonance_q) * sigma) >>> QF);
    sig      = clamp_range((longint'(loop_norm_q) * diff) >>> QF, INTEG_MIN, INTEG_MAX);
    for (i = 0; i < STAGES; i++) begin
      s              = integ_state[i];
      v              = ((sig - s) * longint'(stage_gain_q)) >>> QF;
      lp             = clamp_range(v + s, INTEG_MIN, INTEG_MAX);
      integ_state[i] = clamp_range(v + lp, INTEG_MIN, INTEG_MAX);
      sig            = lp;
    end
    return SAMPLE_BITS'(clamp_range(sig, OUT_MIN, OUT_MAX));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      stage_gain_q = COEF_W'(ONE_Q / 2);
      loop_norm_q  = COEF_W'(ONE_Q);
      resonance_q  = '0;
      bass_comp_q  = '0;
      for (int i = 0; i < STAGES; i++) begin
        beta_q[i]      = '0;
        integ_state[i] = 0;
      end
      expected_samples.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_STAGE_GAIN: stage_gain_q = cfg_ch.data[COEF_W-1:0];
          REG_LOOP_NORM:  loop_norm_q  = cfg_ch.data[COEF_W-1:0];
          REG_RESONANCE:  resonance_q  = cfg_ch.data[RES_W-1:0];
          REG_BASS_COMP:  bass_comp_q  = cfg_ch.data[COEF_W-1:0];
          REG_BETA_ONE:   beta_q[0]    = cfg_ch.data[COEF_W-1:0];
          REG_BETA_TWO:   beta_q[1]    = cfg_ch.data[COEF_W-1:0];
          REG_BETA_THREE: beta_q[2]    = cfg_ch.data[COEF_W-1:0];
          REG_BETA_FOUR:  beta_q[3]    = cfg_ch.data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_samples.push_back(ladder_filter_step(in_ch.sample_in));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_samples.size() == 0) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("check: unexpected sample_out %0d with nothing pending",
                     out_ch.sample_out);
          end
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_ch.sample_out !== want) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("check: result %0d sample_out expected %0d got %0d",
                       results_checked, want, out_ch.sample_out);
            end
            mismatch_count++;
          end
        end
      end
    end
    pending_count = expected_samples.size();
  end

endmodule

### verif/tb_four_pole_ladder_lowpass.sv
// ----------------------------------------------------------------------------
// tb_four_pole_ladder_lowpass: testbench for the four-pole ladder lowpass
// Directed extremes then random audio over several coefficient sets, with
// bursty input, a stalling output side and a checker that predicts results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_four_pole_ladder_lowpass;
  import fpl_pkg::*;

  localparam int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS;
  localparam int          NUM_REGS        = 8;
  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 100;
  localparam int          FLOOD_ITEMS     = 30;   // offered while the output is held off
  localparam int          HOLD_CYCLES     = 600;  // long output hold, well past two items
  localparam int          SETTLE_CYCLES   = 60;   // settle margin, longer than the block latency

  localparam logic [CFG_DATA_W-1:0] Q_ONE         = CFG_DATA_W'(ONE_Q);
  localparam logic [CFG_DATA_W-1:0] COEF_ALL_ONES = CFG_DATA_W'((1 << COEF_W) - 1);
  localparam logic [CFG_DATA_W-1:0] RES_ALL_ONES  = CFG_DATA_W'((1 << RES_W) - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Output-side stall styles
  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int failures;
  int pending;
  int checked;
  int items_sent    = 0;
  int hold_requests = 0;

  fpl_cfg_if cfg_ch ();
  fpl_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  fpl_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  four_pole_ladder_lowpass #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ladder_response_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .failures_o (failures),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drives are applied at the falling edge; handshakes are judged from the
  // values seen just as the rising edge wakes us, before any register update.
  // valid is left high on return so a burst keeps it up between items.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    in_ch.valid     = 1'b1;
    in_ch.sample_in = value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Block is idle once the checker holds no outstanding predictions
  task automatic wait_for_results();
    while (pending != 0) @(negedge clk);
  endtask

  // Mix of rails, quiet signal near zero and full-scale noise
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 1023)) - 512);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Output side: ready pattern of its own, switching style at random intervals,
  // plus a long hold-off whenever the stimulus asks for one.
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       holds_served;
    int       run_left;
    logic     run_level;
    mode         = RX_STREAM;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    run_left     = 0;
    run_level    = 1'b1;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (mode)
          RX_STREAM: out_ch.ready = 1'b1;
          RX_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready = ($urandom_range(0, 4) == 0);
          default: begin
            // alternating runs of ready and stall of random length
            if (run_left == 0) begin
              run_level = !run_level;
              run_left  = $urandom_range(1, 30);
            end
            run_left--;
            out_ch.ready = run_level;
          end
        endcase
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb: run did not complete in time");
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0]         setting [NUM_REGS];
    logic signed [SAMPLE_BITS-1:0] opening [14];
    logic signed [SAMPLE_BITS-1:0] rails [8];
    int                            phase;
    int                            r;
    int                            remaining;
    int                            burst;
    int                            gap;
    bit                            no_gaps;

    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_STAGE_GAIN;
    cfg_ch.data     = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset coefficients: zero, held rails (step response), -1/+1 LSB,
    // alternating bit patterns for every input bit, then back to zero.
    opening = '{SAMPLE_BITS'(0), SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                SAMPLE_BITS'(-1), SAMPLE_BITS'(1), 24'h555555, 24'hAAAAAA,
                SAMPLE_BITS'(0)};
    foreach (opening[n]) send_sample(opening[n]);
    in_ch.valid = 1'b0;
    wait_for_results();

    // Every coefficient at its nominal top value: heaviest feedback and input boost,
    // so the output clamp and the 32-bit saturation are exercised.
    setting[REG_STAGE_GAIN] = Q_ONE;
    setting[REG_LOOP_NORM]  = Q_ONE;
    setting[REG_RESONANCE]  = CFG_DATA_W'(4 * ONE_Q);
    setting[REG_BASS_COMP]  = Q_ONE;
    setting[REG_BETA_ONE]   = Q_ONE;
    setting[REG_BETA_TWO]   = Q_ONE;
    setting[REG_BETA_THREE] = Q_ONE;
    setting[REG_BETA_FOUR]  = Q_ONE;
    for (r = 0; r < NUM_REGS; r++) write_register(cfg_idx_e'(r), setting[r]);
    rails = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
              SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
    foreach (rails[n]) send_sample(rails[n]);
    in_ch.valid = 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      wait_for_results();

      // Random coefficients in range, then shaped per phase
      setting[REG_STAGE_GAIN] = CFG_DATA_W'($urandom_range(0, ONE_Q));
      setting[REG_LOOP_NORM]  = CFG_DATA_W'($urandom_range(0, ONE_Q));
      setting[REG_RESONANCE]  = CFG_DATA_W'($urandom_range(0, 4 * ONE_Q));
      setting[REG_BASS_COMP]  = CFG_DATA_W'($urandom_range(0, ONE_Q));
      setting[REG_BETA_ONE]   = CFG_DATA_W'($urandom_range(0, ONE_Q));
      setting[REG_BETA_TWO]   = CFG_DATA_W'($urandom_range(0, ONE_Q));
      setting[REG_BETA_THREE] = CFG_DATA_W'($urandom_range(0, ONE_Q));
      setting[REG_BETA_FOUR]  = CFG_DATA_W'($urandom_range(0, ONE_Q));
      case (phase)
        0: begin
          // all-ones register contents, above the nominal maxima
          setting[REG_STAGE_GAIN] = COEF_ALL_ONES;
          setting[REG_LOOP_NORM]  = COEF_ALL_ONES;
          setting[REG_RESONANCE]  = RES_ALL_ONES;
          setting[REG_BASS_COMP]  = COEF_ALL_ONES;
          setting[REG_BETA_ONE]   = COEF_ALL_ONES;
          setting[REG_BETA_TWO]   = COEF_ALL_ONES;
          setting[REG_BETA_THREE] = COEF_ALL_ONES;
          setting[REG_BETA_FOUR]  = COEF_ALL_ONES;
        end
        1: begin
          // zero gain and zero loop normalisation: the states freeze
          setting[REG_STAGE_GAIN] = '0;
          setting[REG_LOOP_NORM]  = '0;
        end
        2: begin
          // plain four-pole lowpass, no feedback, no bass compensation
          setting[REG_LOOP_NORM] = Q_ONE;
          setting[REG_RESONANCE] = '0;
          setting[REG_BASS_COMP] = '0;
        end
        3: begin
          // near self-oscillation with ladder-like weights in beta three and beta four
          setting[REG_RESONANCE]  = CFG_DATA_W'($urandom_range(7 * ONE_Q / 2, 4 * ONE_Q));
          setting[REG_BETA_FOUR]  = Q_ONE - setting[REG_STAGE_GAIN];
          setting[REG_BETA_THREE] = setting[REG_BETA_FOUR] >> 1;
        end
        default: ;
      endcase
      for (r = 0; r < NUM_REGS; r++) write_register(cfg_idx_e'(r), setting[r]);

      // Output held off for a long stretch while items keep coming, so the
      // block fills up and pushes back on its input.
      if (phase == 5) begin
        hold_requests++;
        repeat (FLOOD_ITEMS) send_sample(random_sample());
        in_ch.valid = 1'b0;
      end

      // One phase runs with no input gaps at all
      no_gaps   = (phase == 4);
      remaining = ITEMS_PER_PHASE;
      while (remaining > 0) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && remaining > 0) begin
          send_sample(random_sample());
          burst--;
          remaining--;
          // Mid-phase, the input waits for the pipeline to empty completely
          if (phase == 6 && remaining == ITEMS_PER_PHASE / 2) begin
            in_ch.valid = 1'b0;
            wait_for_results();
          end
        end
        if (no_gaps) begin
          gap = 0;
        end else if ($urandom_range(0, 3) == 0) begin
          gap = $urandom_range(40, 120);
        end else begin
          gap = $urandom_range(0, 20);
        end
        if (gap > 0) begin
          in_ch.valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_ch.valid = 1'b0;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d samples sent over %0d coefficient sets, %0d results checked",
             items_sent, PHASES + 2, checked);
    $display("tb: covered rails, saturation, frozen states and a full output backlog");
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
